/* sv/lru_set_assoc_cache_lookup_unit_assert.svh */
// Assertion macros for the cache lookup unit; they assume clk and rst in scope.
`ifndef LRU_SET_ASSOC_CACHE_LOOKUP_UNIT_ASSERT_SVH
`define LRU_SET_ASSOC_CACHE_LOOKUP_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define LSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache lookup assertion failed");
`define LSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache lookup assertion failed");
`else
`define LSC_ASSERT_IMP(lbl, ante, cons)
`define LSC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* sv/lsc_pkg.sv */
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and codes of the LRU cache lookup unit.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int CFG_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  typedef struct packed {
    logic clear;    // zero one set of metadata
    logic capture;  // latch the access and read its set
    logic update;   // resolve the lookup and write the set back
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } status_t;

endpackage

/* sv/lsc_ctrl.sv */
// ----------------------------------------------------------------------------
// lsc_ctrl
// Sequencer: clearing pass after reset, then capture / update per access.
// ----------------------------------------------------------------------------
`include "lru_set_assoc_cache_lookup_unit_assert.svh"

module lsc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  lsc_pkg::status_t status,
  output lsc_pkg::cmd_t    cmd,
  output logic             busy
);

  lsc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    busy        = 1'b1;
    unique case (state)
      lsc_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = lsc_pkg::ST_IDLE;
        end
      end
      lsc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = lsc_pkg::ST_LOOK;
        end
      end
      lsc_pkg::ST_LOOK: begin
        cmd.update = 1'b1;
        state_next = lsc_pkg::ST_IDLE;
      end
      default: begin
        state_next = lsc_pkg::ST_CLEAR;
      end
    endcase
  end

  `LSC_ASSERT_NXT(a_accept_looks, start && !busy, state == lsc_pkg::ST_LOOK)
  `LSC_ASSERT_NXT(a_look_one_cycle, state == lsc_pkg::ST_LOOK, state == lsc_pkg::ST_IDLE)
  `LSC_ASSERT_IMP(a_clear_busy, state == lsc_pkg::ST_CLEAR, busy && !cmd.capture)

endmodule

/* sv/lsc_dp.sv */
// ----------------------------------------------------------------------------
// lsc_dp
// Datapath: set memories, tag compare, LRU rank update, result register.
// ----------------------------------------------------------------------------
module lsc_dp #(
  parameter int MAX_SETS   = 1024,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lsc_pkg::cmd_t             cmd,
  output lsc_pkg::status_t          status,
  input  logic [lsc_pkg::CFG_W-1:0] offset_bits,
  input  logic [lsc_pkg::CFG_W-1:0] set_bits,
  input  logic [lsc_pkg::CFG_W-1:0] ways_in_use,
  input  logic                      operation,
  input  logic [ADDR_WIDTH-1:0]     address,
  output logic                      done,
  output logic                      hit
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int AGE_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int FILL_W = $clog2(MAX_WAYS + 1);
  localparam int META_W = FILL_W + MAX_WAYS * AGE_W + MAX_WAYS;
  localparam int TAGS_W = MAX_WAYS * ADDR_WIDTH;

  logic [TAGS_W-1:0] tag_mem  [MAX_SETS];
  logic [META_W-1:0] meta_mem [MAX_SETS];

  logic [TAGS_W-1:0]     tag_rd;
  logic [META_W-1:0]     meta_rd;
  logic [SET_W-1:0]      clr_idx;
  logic [SET_W-1:0]      cur_set;
  logic [ADDR_WIDTH-1:0] cur_tag;
  logic                  cur_op;

  logic [ADDR_WIDTH-1:0] in_tag;
  logic [SET_W-1:0]      in_set;
  logic [SET_W-1:0]      set_mask;
  logic [3:0]            sb;
  logic [FILL_W-1:0]     ways_eff;

  logic [TAGS_W-1:0] tag_wd;
  logic [META_W-1:0] meta_wd;
  logic              tag_we;
  logic              hit_c;

  assign status.clear_last = (clr_idx == SET_W'(MAX_SETS - 1));

  // Set index from the incoming address; sets above the array are folded off.
  always_comb begin
    sb       = (int'(set_bits) > SB_MAX) ? 4'(SB_MAX) : set_bits;
    set_mask = ~({SET_W{1'b1}} << sb);
    in_tag   = address >> offset_bits;
    in_set   = in_tag[SET_W-1:0] & set_mask;
    if (ways_in_use == '0) begin
      ways_eff = FILL_W'(1);
    end else if (int'(ways_in_use) > MAX_WAYS) begin
      ways_eff = FILL_W'(MAX_WAYS);
    end else begin
      ways_eff = FILL_W'(ways_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_tag <= in_tag;
      cur_set <= in_set;
      cur_op  <= operation;
      tag_rd  <= tag_mem[in_set];
      meta_rd <= meta_mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      meta_mem[clr_idx] <= '0;
    end else if (cmd.update) begin
      meta_mem[cur_set] <= meta_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && tag_we) begin
      tag_mem[cur_set] <= tag_wd;
    end
  end

  // Lookup and LRU update over the ways of the captured set.
  always_comb begin
    logic [MAX_WAYS-1:0]   vld;
    logic [AGE_W-1:0]      age [MAX_WAYS];
    logic [ADDR_WIDTH-1:0] tg  [MAX_WAYS];
    logic [FILL_W-1:0]     fill;
    logic [AGE_W-1:0]      hw, slot, vic, pick, old;
    logic                  fh, fs, fv, promote;

    vld  = meta_rd[MAX_WAYS-1:0];
    fill = meta_rd[META_W-1 -: FILL_W];
    for (int w = 0; w < MAX_WAYS; w++) begin
      age[w] = meta_rd[MAX_WAYS + w*AGE_W +: AGE_W];
      tg[w]  = tag_rd[w*ADDR_WIDTH +: ADDR_WIDTH];
    end

    fh = 1'b0; hw = '0;
    fs = 1'b0; slot = '0;
    fv = 1'b0; vic = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!fh && vld[w] && tg[w] == cur_tag) begin
        fh = 1'b1;
        hw = AGE_W'(w);
      end
      if (!fs && !vld[w]) begin
        fs   = 1'b1;
        slot = AGE_W'(w);
      end
      if (vld[w] && (!fv || age[w] > age[vic])) begin
        fv  = 1'b1;
        vic = AGE_W'(w);
      end
    end
    hit_c  = fh;
    tag_we = 1'b0;
    promote = 1'b0;
    pick   = hw;
    old    = '0;

    if (fh) begin
      promote = 1'b1;
    end else if (cur_op == lsc_pkg::OP_LOAD) begin
      tag_we = 1'b1;
      if (fill < ways_eff) begin
        for (int w = 0; w < MAX_WAYS; w++) begin
          if (vld[w]) age[w] = age[w] + 1'b1;
        end
        vld[slot] = 1'b1;
        age[slot] = '0;
        tg[slot]  = cur_tag;
        fill      = fill + 1'b1;
      end else begin
        tg[vic] = cur_tag;
        pick    = vic;
        promote = 1'b1;
      end
    end

    if (promote) begin
      old = age[pick];
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (vld[w] && age[w] < old) age[w] = age[w] + 1'b1;
      end
      age[pick] = '0;
    end

    for (int w = 0; w < MAX_WAYS; w++) begin
      tag_wd[w*ADDR_WIDTH +: ADDR_WIDTH] = tg[w];
      meta_wd[MAX_WAYS + w*AGE_W +: AGE_W] = age[w];
    end
    meta_wd[MAX_WAYS-1:0]        = vld;
    meta_wd[META_W-1 -: FILL_W]  = fill;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit <= hit_c;
    end
  end

endmodule

/* sv/lru_set_assoc_cache_lookup_unit.sv */
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_lookup_unit
// Set-associative cache directory with LRU replacement, write-through and
// no write-allocate; answers hit or miss for each load or store.
//
//   Channel  Handshake            Payload
//   access   start / busy         operation, address
//   result   done (1-cycle beat)  hit
//   config   cfg_we               cfg_index, cfg_data
//
// An access latches its set row when accepted, then in LOOK compares tags,
// updates ranks and writes the row back with busy high, so no new access is
// taken meanwhile. The result beat is registered from the write-back cycle
// and appears in the cycle after it, alongside the next accept. After reset
// a clearing pass zeroes one set per cycle, MAX_SETS sets (1024 by default),
// with busy high. Results cannot be stalled; done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module lru_set_assoc_cache_lookup_unit #(
  parameter int MAX_SETS   = 1024,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [ADDR_WIDTH-1:0]         address,
  output logic                          done,
  output logic                          hit,
  input  logic                          cfg_we,
  input  logic [lsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsc_pkg::CFG_W-1:0]     cfg_data
);

  logic [lsc_pkg::CFG_W-1:0] offset_bits;
  logic [lsc_pkg::CFG_W-1:0] set_bits;
  logic [lsc_pkg::CFG_W-1:0] ways_in_use;
  lsc_pkg::cmd_t             cmd;
  lsc_pkg::status_t          status;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= 4'd2;
      set_bits    <= 4'd0;
      ways_in_use <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsc_pkg::CFG_OFFSET_BITS: offset_bits <= cfg_data;
        lsc_pkg::CFG_SET_BITS:    set_bits    <= cfg_data;
        lsc_pkg::CFG_WAYS_IN_USE: ways_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  lsc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  lsc_dp #(
    .MAX_SETS   (MAX_SETS),
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .offset_bits (offset_bits),
    .set_bits    (set_bits),
    .ways_in_use (ways_in_use),
    .operation   (operation),
    .address     (address),
    .done        (done),
    .hit         (hit)
  );

endmodule

/* tb/tb_lru_set_assoc_cache_lookup_unit.sv */
// ----------------------------------------------------------------------------
// tb_lru_set_assoc_cache_lookup_unit
// Drives loads and stores into the LRU cache lookup unit under a range of
// geometries and checks every hit flag against a behavioral copy of the set
// directory kept inside the bench.
// ----------------------------------------------------------------------------
module tb_lru_set_assoc_cache_lookup_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSETS = 1024;
  localparam int NWAYS = 8;
  localparam int AW = 24;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [lsc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk, rst, start, busy, operation, done, hit, cfg_we;
  logic [AW-1:0] address;
  logic [lsc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lsc_pkg::CFG_W-1:0] cfg_data;

  lru_set_assoc_cache_lookup_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .address(address), .done(done), .hit(hit), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // directory copy
  logic [AW-1:0] dir_tag [NSETS*NWAYS];
  bit dir_valid [NSETS*NWAYS];
  int dir_age [NSETS*NWAYS];
  int dir_fill [NSETS];
  int offset_sh, set_sh, way_cnt;

  bit hit_due [$];
  int mismatches;
  int cycles;
  bit no_idle;
  logic [AW-1:0] addr_pool [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void promote(int base, int idx);
    int old;
    old = dir_age[base+idx];
    for (int w = 0; w < NWAYS; w++)
      if (dir_valid[base+w] && dir_age[base+w] < old) dir_age[base+w]++;
    dir_age[base+idx] = 0;
  endfunction

  function automatic bit lookup_and_update(logic op, logic [AW-1:0] addr);
    int sb, wy, set_i, base, hw, slot, victim;
    logic [AW-1:0] tg;
    bit found;
    sb = set_sh;
    while (sb > 0 && (1 << sb) > NSETS) sb--;
    wy = (way_cnt == 0) ? 1 : (way_cnt > NWAYS) ? NWAYS : way_cnt;
    tg = addr >> offset_sh;
    set_i = int'(tg) & ((1 << sb) - 1);
    base = set_i * NWAYS;
    found = 0;
    hw = 0;
    for (int w = 0; w < NWAYS; w++)
      if (!found && dir_valid[base+w] && dir_tag[base+w] == tg) begin
        found = 1;
        hw = w;
      end
    if (found) begin
      promote(base, hw);
    end else if (op == lsc_pkg::OP_LOAD) begin
      if (dir_fill[set_i] < wy) begin
        slot = -1;
        for (int w = 0; w < NWAYS; w++)
          if (slot < 0 && !dir_valid[base+w]) slot = w;
        for (int w = 0; w < NWAYS; w++)
          if (dir_valid[base+w]) dir_age[base+w]++;
        dir_valid[base+slot] = 1;
        dir_tag[base+slot] = tg;
        dir_age[base+slot] = 0;
        dir_fill[set_i]++;
      end else begin
        victim = -1;
        for (int w = 0; w < NWAYS; w++)
          if (dir_valid[base+w] && (victim < 0 || dir_age[base+w] > dir_age[base+victim]))
            victim = w;
        dir_tag[base+victim] = tg;
        promote(base, victim);
      end
    end
    return found;
  endfunction

  // check each result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (hit_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: hit=%0b", hit);
      end else begin
        automatic bit exp_hit = hit_due.pop_front();
        if (hit !== exp_hit) begin
          mismatches++;
          if (mismatches <= 10) $display("hit mismatch: expected %0b, got %0b", exp_hit, hit);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // send one access; start stays high afterwards until the next call decides
  task automatic access(logic op, logic [AW-1:0] addr);
    if (!no_idle && $urandom_range(99) < 34) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    operation = op;
    address = addr;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    hit_due.push_back(lookup_and_update(op, addr));
  endtask

  // hold off until every beat is back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (hit_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [lsc_pkg::CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val[lsc_pkg::CFG_W-1:0];
    case (idx)
      lsc_pkg::CFG_OFFSET_BITS: offset_sh = val & 15;
      lsc_pkg::CFG_SET_BITS: set_sh = val & 15;
      lsc_pkg::CFG_WAYS_IN_USE: way_cnt = val & 15;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_geometry(int off, int sb, int wy);
    drain();
    write_reg(lsc_pkg::CFG_OFFSET_BITS, off);
    write_reg(lsc_pkg::CFG_SET_BITS, sb);
    write_reg(lsc_pkg::CFG_WAYS_IN_USE, wy);
  endtask

  task automatic test_reset_geometry();
    access(lsc_pkg::OP_LOAD, 24'h000000);
    access(lsc_pkg::OP_LOAD, 24'h000000);
    access(lsc_pkg::OP_STORE, 24'h000003);
    access(lsc_pkg::OP_STORE, 24'h000004);
    access(lsc_pkg::OP_LOAD, 24'h000004);
    access(lsc_pkg::OP_LOAD, 24'h000000);
    access(lsc_pkg::OP_LOAD, 24'hFFFFFF);
    access(lsc_pkg::OP_STORE, 24'hFFFFFC);
  endtask

  task automatic test_open_cases();
    drain();
    write_reg(CFG_UNUSED, 15);  // nonexistent register: no effect
    set_geometry(15, 15, 0);
    access(lsc_pkg::OP_LOAD, 24'h007FFF);
    access(lsc_pkg::OP_LOAD, 24'h000000);
    access(lsc_pkg::OP_LOAD, 24'hFFFFFF);
    access(lsc_pkg::OP_STORE, 24'hFF8000);
    set_geometry(0, 0, 15);
    for (int i = 1; i <= 8; i++) access(lsc_pkg::OP_LOAD, AW'(i));
    // shrink associativity while the set is full
    set_geometry(0, 0, 2);
    access(lsc_pkg::OP_LOAD, 24'h000009);
    access(lsc_pkg::OP_LOAD, 24'h000002);
    access(lsc_pkg::OP_STORE, 24'h000001);
  endtask

  task automatic test_random_traffic();
    int geo [12][3] = '{'{2, 0, 1}, '{0, 0, 8}, '{0, 0, 2}, '{10, 10, 8},
                         '{15, 15, 15}, '{4, 3, 4}, '{0, 10, 1}, '{7, 2, 0},
                         '{3, 1, 3}, '{1, 4, 8}, '{6, 2, 5}, '{0, 1, 8}};
    logic [AW-1:0] a;
    for (int p = 0; p < 12; p++) begin
      set_geometry(geo[p][0], geo[p][1], geo[p][2]);
      if (p == 0 || $urandom_range(1)) begin
        addr_pool.delete();
        repeat ($urandom_range(4, 40)) addr_pool.push_back(AW'($urandom));
      end
      no_idle = (p == 5);
      repeat (118) begin
        if ($urandom_range(99) < 75) begin
          a = addr_pool[$urandom_range(addr_pool.size() - 1)];
          a = a ^ (AW'($urandom) & ((AW'(1) << offset_sh) - 1));
        end else begin
          a = AW'($urandom);
        end
        access(logic'($urandom_range(99) < 35), a);
      end
      no_idle = 0;
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    operation = 1'b0;
    address = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    no_idle = 0;
    offset_sh = 2;
    set_sh = 0;
    way_cnt = 1;
    for (int i = 0; i < NSETS*NWAYS; i++) begin
      dir_tag[i] = '0;
      dir_valid[i] = 0;
      dir_age[i] = 0;
    end
    for (int i = 0; i < NSETS; i++) dir_fill[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // wait out the clearing pass
    while (busy) @(negedge clk);

    test_reset_geometry();
    test_open_cases();
    test_random_traffic();
    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && hit_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/lsc_pkg.sv
sv/lsc_ctrl.sv
sv/lsc_dp.sv
sv/lru_set_assoc_cache_lookup_unit.sv
tb/tb_lru_set_assoc_cache_lookup_unit.sv
